FILE: sv/dlr_pkg.sv
`timescale 1ns / 1ps

package dlr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef struct packed {
		logic accept;
		logic start;
		logic div_en;
		logic emit;
	} dlr_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} dlr_sts_t;

endpackage

FILE: sv/dda_line_rasterizer.sv
`timescale 1ns / 1ps
// Step item: after acceptance the controller enters the emit state and registers the result once
// the output register is free. Start item: the controller first runs the restoring divider, which
// produces one quotient bit per cycle for both axes, FRAC_BITS + 1 bits each, then emits as above.
// No new item is taken until the controller is back in idle.
// Only one item is in flight; the output register holds a result while the next item enters.
// Asynchronous active-low reset clears the controller, the line state and the output valid.

module dda_line_rasterizer #(
	parameter int COORD_BITS = 11,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic                  gray_pen,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  pixel_gray,
	output logic                  pixel_valid,
	output logic                  pixel_last
);
	import dlr_pkg::*;

	dlr_cmd_t cmd;
	dlr_sts_t sts;

	dlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dlr_datapath #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.gray_pen    (gray_pen),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_gray  (pixel_gray),
		.pixel_valid (pixel_valid),
		.pixel_last  (pixel_last)
	);

endmodule

FILE: sv/dlr_ctrl.sv
`timescale 1ns / 1ps

module dlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	output logic              in_stall,
	input  dlr_pkg::dlr_sts_t sts,
	output dlr_pkg::dlr_cmd_t cmd
);
	import dlr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (opcode == OP_START) ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign cmd.accept = in_valid && (state_q == ST_IDLE);
	assign cmd.start  = cmd.accept && (opcode == OP_START);
	assign cmd.div_en = (state_q == ST_DIV);
	assign cmd.emit   = (state_q == ST_EMIT) && sts.out_free;

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while the output register is occupied");

	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> (state_q == ST_EMIT))
		else $error("division finished without moving to emit");

	a_accept_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_DIV || state_q == ST_EMIT))
		else $error("accepted item did not leave idle");

endmodule

FILE: sv/dlr_datapath.sv
`timescale 1ns / 1ps

module dlr_datapath #(
	parameter int COORD_BITS = 11,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dlr_pkg::dlr_cmd_t     cmd,
	output dlr_pkg::dlr_sts_t     sts,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic                  gray_pen,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  pixel_gray,
	output logic                  pixel_valid,
	output logic                  pixel_last
);
	import dlr_pkg::*;

	localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
	localparam int STEP_W = FRAC_BITS + 2;
	localparam int LEFT_W = COORD_BITS + 1;
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(FRAC_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

	function automatic logic [COORD_BITS-1:0] pixel_of(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] sum;
		sum = pos + {{(POS_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
		return sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
	endfunction

	// Line state
	logic [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;
	logic [LEFT_W-1:0] pixels_left_q;
	logic              line_gray_q;

	// Divider state
	logic [COORD_BITS-1:0] k_q;
	logic [COORD_BITS-1:0] rem_x_q, rem_y_q;
	logic [Q_W-1:0]        quo_x_q, quo_y_q;
	logic                  neg_x_q, neg_y_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  op_q;

	// Output register
	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic                  out_gray_q, out_pvalid_q, out_last_q;

	// Start decode
	logic [COORD_BITS-1:0] adx, ady, k_in;
	logic                  nx_in, ny_in;

	always_comb begin
		nx_in = (end_x < start_x);
		ny_in = (end_y < start_y);
		adx   = nx_in ? (start_x - end_x) : (end_x - start_x);
		ady   = ny_in ? (start_y - end_y) : (end_y - start_y);
		k_in  = (adx >= ady) ? adx : ady;
	end

	// One restoring division step per axis. The first step weighs the 1.0 bit
	// and so compares the unshifted remainder.
	logic [COORD_BITS:0]   trial_x, trial_y;
	logic                  take_x, take_y;
	logic [COORD_BITS-1:0] rem_x_d, rem_y_d;

	always_comb begin
		trial_x = (cnt_q == '0) ? {1'b0, rem_x_q} : {rem_x_q, 1'b0};
		trial_y = (cnt_q == '0) ? {1'b0, rem_y_q} : {rem_y_q, 1'b0};
		take_x  = (trial_x >= {1'b0, k_q});
		take_y  = (trial_y >= {1'b0, k_q});
		rem_x_d = take_x ? COORD_BITS'(trial_x - {1'b0, k_q}) : trial_x[COORD_BITS-1:0];
		rem_y_d = take_y ? COORD_BITS'(trial_y - {1'b0, k_q}) : trial_y[COORD_BITS-1:0];
	end

	// Signed increments from the finished quotients
	logic [STEP_W-1:0] qx_ext, qy_ext, inc_x, inc_y;

	always_comb begin
		qx_ext = {1'b0, quo_x_q};
		qy_ext = {1'b0, quo_y_q};
		if (k_q == '0) begin
			inc_x = '0;
			inc_y = '0;
		end else begin
			inc_x = neg_x_q ? (~qx_ext + STEP_W'(1)) : qx_ext;
			inc_y = neg_y_q ? (~qy_ext + STEP_W'(1)) : qy_ext;
		end
	end

	// Advance for a step item
	logic [POS_W-1:0]  pos_x_nx, pos_y_nx;
	logic [LEFT_W-1:0] left_nx;

	always_comb begin
		pos_x_nx = pos_x_q + {{(POS_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
		pos_y_nx = pos_y_q + {{(POS_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
		left_nx  = pixels_left_q - LEFT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			step_x_q      <= '0;
			step_y_q      <= '0;
			pixels_left_q <= '0;
			line_gray_q   <= 1'b0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				pos_x_q       <= {1'b0, start_x, {FRAC_BITS{1'b0}}};
				pos_y_q       <= {1'b0, start_y, {FRAC_BITS{1'b0}}};
				line_gray_q   <= gray_pen;
				pixels_left_q <= (k_in == '0) ? '0 : ({1'b0, k_in} - LEFT_W'(1));
				cnt_q         <= '0;
			end else if (cmd.div_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				if (op_q == OP_START) begin
					step_x_q <= inc_x;
					step_y_q <= inc_y;
				end else if (pixels_left_q != '0) begin
					pos_x_q       <= pos_x_nx;
					pos_y_q       <= pos_y_nx;
					pixels_left_q <= left_nx;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= opcode;
		end
		if (cmd.start) begin
			k_q     <= k_in;
			rem_x_q <= adx;
			rem_y_q <= ady;
			neg_x_q <= nx_in;
			neg_y_q <= ny_in;
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (cmd.div_en) begin
			rem_x_q <= rem_x_d;
			rem_y_q <= rem_y_d;
			quo_x_q <= {quo_x_q[Q_W-2:0], take_x};
			quo_y_q <= {quo_y_q[Q_W-2:0], take_y};
		end
		if (cmd.emit) begin
			if (op_q == OP_START) begin
				out_x_q      <= pixel_of(pos_x_q);
				out_y_q      <= pixel_of(pos_y_q);
				out_gray_q   <= line_gray_q;
				out_pvalid_q <= 1'b1;
				out_last_q   <= (pixels_left_q == '0);
			end else if (pixels_left_q == '0) begin
				// No line is active: an empty result.
				out_x_q      <= '0;
				out_y_q      <= '0;
				out_gray_q   <= 1'b0;
				out_pvalid_q <= 1'b0;
				out_last_q   <= 1'b0;
			end else begin
				out_x_q      <= pixel_of(pos_x_nx);
				out_y_q      <= pixel_of(pos_y_nx);
				out_gray_q   <= line_gray_q;
				out_pvalid_q <= 1'b1;
				out_last_q   <= (left_nx == '0);
			end
		end
	end

	assign sts.div_last = (cnt_q == CNT_LAST);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_gray  = out_gray_q;
	assign pixel_valid = out_pvalid_q;
	assign pixel_last  = out_last_q;

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("output became valid without a result being loaded");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_en |-> (cnt_q <= CNT_LAST))
		else $error("division counter ran past the last quotient bit");

	a_left_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && op_q == OP_STEP && pixels_left_q != '0)
		|=> (pixels_left_q == $past(left_nx)))
		else $error("pixel count did not step down on a step item");

endmodule

FILE: test/tb_dda_line_rasterizer.sv
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;
	import dlr_pkg::*;

	localparam int COORD_BITS = 11;
	localparam int FRAC_BITS  = 16;
	localparam int POS_BITS   = COORD_BITS + FRAC_BITS + 1;
	localparam int INC_BITS   = FRAC_BITS + 2;
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
		logic                  gray;
	} line_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  gray;
		logic                  valid;
		logic                  last;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  opcode;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic                  gray_pen;
	logic                  out_valid;
	logic                  out_stall;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  pixel_gray;
	logic                  pixel_valid;
	logic                  pixel_last;

	// Line state as the block should hold it.
	logic [POS_BITS-1:0]   pen_x, pen_y;
	logic [INC_BITS-1:0]   inc_x, inc_y;
	logic [COORD_BITS:0]   pixels_to_go;
	logic                  pen_gray;

	line_item_t pending_items[$];
	pixel_t     expected_pixels[$];
	logic       in_fire;
	int         send_idle_pct;
	int         stall_pct;
	int         items_queued;
	int         lines_started;
	int         results_seen;
	int         no_line_results;
	int         lines_ended;
	int         mismatches;

	dda_line_rasterizer #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.gray_pen   (gray_pen),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_gray (pixel_gray),
		.pixel_valid(pixel_valid),
		.pixel_last (pixel_last)
	);

	always #5 clk = ~clk;

	function automatic logic [COORD_BITS-1:0] ceil_coord(logic [POS_BITS-1:0] pos);
		logic [POS_BITS-1:0] rounded;
		rounded = pos + POS_BITS'((1 << FRAC_BITS) - 1);
		return rounded[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
	endfunction

	// Signed per-axis increment, truncated toward zero.
	function automatic logic [INC_BITS-1:0] axis_increment(int a, int b, int k);
		longint mag;
		longint q;
		if (k == 0)
			return '0;
		mag = (b > a) ? b - a : a - b;
		q = (mag << FRAC_BITS) / k;
		return (b < a) ? INC_BITS'(-q) : INC_BITS'(q);
	endfunction

	function automatic int line_span(int x1, int y1, int x2, int y2);
		int dx, dy;
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		return (dx > dy) ? dx : dy;
	endfunction

	task automatic rasterize(line_item_t it);
		int k;
		if (it.op == OP_START) begin
			k = line_span(int'(it.sx), int'(it.sy), int'(it.ex), int'(it.ey));
			inc_x = axis_increment(int'(it.sx), int'(it.ex), k);
			inc_y = axis_increment(int'(it.sy), int'(it.ey), k);
			pen_x = POS_BITS'(it.sx) << FRAC_BITS;
			pen_y = POS_BITS'(it.sy) << FRAC_BITS;
			pen_gray = it.gray;
			pixels_to_go = (k == 0) ? '0 : (COORD_BITS+1)'(k - 1);
			lines_started++;
			expected_pixels.push_back('{ceil_coord(pen_x), ceil_coord(pen_y), pen_gray, 1'b1,
				pixels_to_go == 0});
		end else if (pixels_to_go == 0) begin
			expected_pixels.push_back('{'0, '0, 1'b0, 1'b0, 1'b0});
		end else begin
			pen_x = pen_x + {{(POS_BITS-INC_BITS){inc_x[INC_BITS-1]}}, inc_x};
			pen_y = pen_y + {{(POS_BITS-INC_BITS){inc_y[INC_BITS-1]}}, inc_y};
			pixels_to_go = pixels_to_go - 1'b1;
			expected_pixels.push_back('{ceil_coord(pen_x), ceil_coord(pen_y), pen_gray, 1'b1,
				pixels_to_go == 0});
		end
	endtask

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	function automatic line_item_t junk_step();
		line_item_t it;
		it.op   = OP_STEP;
		it.sx   = COORD_BITS'($urandom_range(COORD_MAX));
		it.sy   = COORD_BITS'($urandom_range(COORD_MAX));
		it.ex   = COORD_BITS'($urandom_range(COORD_MAX));
		it.ey   = COORD_BITS'($urandom_range(COORD_MAX));
		it.gray = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic push_item(line_item_t it);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_line(int x1, int y1, int x2, int y2, logic gray, int steps);
		push_item('{OP_START, COORD_BITS'(x1), COORD_BITS'(y1), COORD_BITS'(x2),
			COORD_BITS'(y2), gray});
		repeat (steps) push_item(junk_step());
	endtask

	function automatic int full_steps(int x1, int y1, int x2, int y2);
		int k;
		k = line_span(x1, y1, x2, y2);
		return (k == 0) ? 0 : k - 1;
	endfunction

	// Waits until every queued item has gone in and every result has come back.
	task automatic drain();
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_lines(int count);
		int goal, pick, span, x1, y1, x2, y2, full;
		goal = items_queued + count;
		while (items_queued < goal) begin
			pick = $urandom_range(99);
			span = $urandom_range(1) ? 3 : 12;
			if (pick < 85) begin
				x1 = $urandom_range(COORD_MAX);
				y1 = $urandom_range(COORD_MAX);
				x2 = clamp_coord(x1 + int'($urandom_range(2 * span)) - span);
				y2 = clamp_coord(y1 + int'($urandom_range(2 * span)) - span);
			end else begin
				x1 = $urandom_range(1) ? $urandom_range(3) : COORD_MAX - $urandom_range(3);
				y1 = $urandom_range(1) ? $urandom_range(3) : COORD_MAX - $urandom_range(3);
				x2 = clamp_coord(x1 + int'($urandom_range(8)) - 4);
				y2 = clamp_coord(y1 + int'($urandom_range(8)) - 4);
			end
			full = full_steps(x1, y1, x2, y2);
			if (pick < 65 || (pick >= 85 && pick < 93)) begin
				// Whole line, now and then followed by a step past its end.
				queue_line(x1, y1, x2, y2, 1'($urandom_range(1)),
					full + int'($urandom_range(1)));
			end else if (pick < 75) begin
				queue_line(x1, y1, x2, y2, 1'($urandom_range(1)),
					int'($urandom_range(full)));
			end else if (pick < 85) begin
				// Long lines across the whole field, cut short by the next start.
				x2 = $urandom_range(COORD_MAX);
				y2 = $urandom_range(COORD_MAX);
				queue_line(x1, y1, x2, y2, 1'($urandom_range(1)),
					int'($urandom_range(4)));
			end else begin
				repeat ($urandom_range(1, 3)) push_item(junk_step());
			end
		end
	endtask

	task automatic run_phase(int idle, int stall, int count);
		send_idle_pct = idle;
		stall_pct = stall;
		random_lines(count);
		drain();
	endtask

	always @(negedge clk) begin : drive
		line_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				in_valid <= 1'b1;
				opcode   <= nxt.op;
				start_x  <= nxt.sx;
				start_y  <= nxt.sy;
				end_x    <= nxt.ex;
				end_y    <= nxt.ey;
				gray_pen <= nxt.gray;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : watch
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				rasterize('{opcode, start_x, start_y, end_x, end_y, gray_pen});
			if (out_valid && !out_stall) begin
				got = '{pixel_x, pixel_y, pixel_gray, pixel_valid, pixel_last};
				results_seen++;
				if (!got.valid)
					no_line_results++;
				else if (got.last)
					lines_ended++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing expected:", $realtime,
							" x=%0d y=%0d gray=%b valid=%b last=%b",
							got.x, got.y, got.gray, got.valid, got.last);
				end else begin
					want = expected_pixels.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.gray !== want.gray ||
							got.valid !== want.valid || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: pixel mismatch:", $realtime,
								" expected x=%0d y=%0d gray=%b valid=%b last=%b,",
								want.x, want.y, want.gray, want.valid, want.last,
								" got x=%0d y=%0d gray=%b valid=%b last=%b",
								got.x, got.y, got.gray, got.valid, got.last);
					end
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("tb_dda_line_rasterizer NOT OK");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = OP_STEP;
		start_x       = '0;
		start_y       = '0;
		end_x         = '0;
		end_y         = '0;
		gray_pen      = 1'b0;
		out_stall     = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		pixels_to_go  = '0;
		pen_x         = '0;
		pen_y         = '0;
		inc_x         = '0;
		inc_y         = '0;
		pen_gray      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// A step before any line, then lines of length zero and one.
		push_item('{OP_STEP, 11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 1'b1});
		queue_line(5, 5, 5, 5, 1'b1, 1);
		queue_line(0, 0, 1, 0, 1'b0, 1);
		// Corner to corner both ways, each cut short by the next start.
		queue_line(COORD_MAX, COORD_MAX, 0, 0, 1'b1, 2);
		queue_line(0, COORD_MAX, COORD_MAX, 0, 1'b0, 2);
		queue_line(0, 0, 3, 7, 1'b1, full_steps(0, 0, 3, 7));
		queue_line(COORD_MAX, 5, COORD_MAX - 4, 6, 1'b0, full_steps(COORD_MAX, 5,
			COORD_MAX - 4, 6));
		drain();

		run_phase(0, 0, 380);
		run_phase(85, 0, 350);
		run_phase(0, 85, 350);
		run_phase(20, 20, 450);

		stall_pct = 0;
		repeat (FRAC_BITS + 12) @(posedge clk);
		$display("Ran %0d items: %0d lines started, %0d results checked against prediction.",
			items_queued, lines_started, results_seen);
		$display("%0d steps found no line, %0d lines reached their last pixel, %0d mismatches.",
			no_line_results, lines_ended, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("tb_dda_line_rasterizer OK");
		else
			$display("tb_dda_line_rasterizer NOT OK");
		$finish;
	end

endmodule
